>>> hw/rtl/two_finger_gesture_detector_unit_assert.svh
// Assertion macros for the port-level checker.
`ifndef TWO_FINGER_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`define TWO_FINGER_GESTURE_DETECTOR_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define TFG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TFG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/tfg_pkg.sv
// Package with shared types and constants of the gesture detector.
`default_nettype none
package tfg_pkg;
  localparam int CoordBits = 16;
  localparam int SumBits = CoordBits + 1;
  localparam int CenBits = CoordBits + 2;
  localparam int SqBits = 2 * CoordBits + 1;
  localparam int DistBits = CoordBits + 10;
  localparam int RootSteps = SqBits / 2 + 9;
  localparam int QuoSteps = DistBits + 16;
  localparam int QuoBits = DistBits + 16;

  localparam logic [2:0] CMD_SLOT = 3'd0;
  localparam logic [2:0] CMD_TRACK = 3'd1;
  localparam logic [2:0] CMD_POS_X = 3'd2;
  localparam logic [2:0] CMD_POS_Y = 3'd3;
  localparam logic [2:0] CMD_SYNC = 3'd4;

  localparam logic [1:0] KIND_TOUCH = 2'd0;
  localparam logic [1:0] KIND_PINCH = 2'd1;
  localparam logic [1:0] KIND_PAN = 2'd2;

  localparam logic CFG_ZOOM = 1'b0;
  localparam logic CFG_PAN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_ROOT, ST_EVAL, ST_DIV, ST_PINCH, ST_PAN, ST_FINISH, ST_OUT, ST_OUT2
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic event_load;
    logic prep;
    logic root_step;
    logic div_start;
    logic div_step;
    logic emit_touch_on;
    logic emit_touch_off;
    logic emit_pinch;
    logic emit_pan;
    logic commit;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic two;
    logic active;
    logic first;
    logic prev_nonzero;
    logic zoom_over;
    logic pan_over;
  } status_t;
endpackage
`default_nettype wire

>>> hw/rtl/two_finger_gesture_detector_unit.sv
// Top level of the two-finger gesture detector.
//  channel   direction  contents
//  s_axis    in         tdata: cmd[2:0], value[34:3]
//  m_axis    out        tdata: kind, touching, center_x, center_y, zoom_ratio, pan_dx, pan_dy
//  cfg       in         cfg_we, cfg_index, cfg_data
// Non-sync events are applied on acceptance and the block stays idle. A sync with two
// placed fingers runs the square root (a load step, then its 25 digits) and, past the
// first frame with a nonzero previous distance, the divider; new requests are taken
// again only once the block is back in idle, after any results are out.
// Reset is synchronous; it clears slot and gesture state and sets the thresholds to their defaults.
// Only one request is in work at a time; a stalled result holds the block.
`default_nettype none
module two_finger_gesture_detector_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // cmd[2:0], value[34:3]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [111:0]     m_axis_tdata,   // kind, touching, center_x, center_y,
                                           // zoom_ratio, pan_dx, pan_dy
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [17:0] cfg_data
);
  tfg_pkg::cmd_t cmd;
  tfg_pkg::status_t status;
  logic [1:0] kind;
  logic touching;
  logic [16:0] cx, cy;
  logic [31:0] zoom;
  logic [17:0] dx, dy;

  tfg_controller u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_cmd(s_axis_tdata[2:0]),
    .in_ready(s_axis_tready), .status, .cmd, .out_valid(m_axis_tvalid),
    .out_last(m_axis_tlast), .out_ready(m_axis_tready)
  );

  tfg_datapath u_dp (
    .clk, .rst, .cmd, .in_cmd(s_axis_tdata[2:0]), .in_value(s_axis_tdata[34:3]),
    .cfg_we, .cfg_index, .cfg_data, .status, .res_kind(kind), .res_touching(touching),
    .res_cx(cx), .res_cy(cy), .res_zoom(zoom), .res_dx(dx), .res_dy(dy)
  );

  assign m_axis_tdata = {7'b0, dy, dx, zoom, cy, cx, touching, kind};
endmodule
`default_nettype wire

>>> hw/rtl/tfg_datapath.sv
// Datapath: slot state, square root, divider, thresholds and result staging.
`default_nettype none
module tfg_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tfg_pkg::cmd_t     cmd,
  input  wire logic [2:0]        in_cmd,
  input  wire logic [31:0]       in_value,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [17:0]       cfg_data,
  output tfg_pkg::status_t       status,
  output logic [1:0]             res_kind,
  output logic                   res_touching,
  output logic [16:0]            res_cx,
  output logic [16:0]            res_cy,
  output logic [31:0]            res_zoom,
  output logic [17:0]            res_dx,
  output logic [17:0]            res_dy
);
  localparam int CB = tfg_pkg::CoordBits;
  localparam int SB = tfg_pkg::SqBits;
  localparam int DB = tfg_pkg::DistBits;
  localparam int QB = tfg_pkg::QuoBits;
  localparam int NB = DB + 16;

  logic [15:0] zoom_threshold;
  logic [17:0] pan_threshold;
  logic [CB-1:0] point_x [2];
  logic [CB-1:0] point_y [2];
  logic [1:0] x_set, y_set, finger_down;
  logic slot_idx, slot_ok;
  logic active, first;
  logic [DB-1:0] prev_dist;
  logic [tfg_pkg::CenBits-1:0] prev_cx, prev_cy;

  logic [SB-1:0] sq;
  logic [SB+16:0] root_src;
  logic [DB+1:0] rem;
  logic [DB-1:0] root;
  logic [NB-1:0] num;
  logic [DB:0] drem;
  logic [QB-1:0] quo;
  logic [tfg_pkg::SumBits-1:0] cx, cy;
  logic [17:0] pdx, pdy;
  logic [31:0] ratio;
  logic zoom_over_r, pan_over_r;

  // Clamp of a signed coordinate to the coordinate range.
  logic [CB-1:0] coord;
  always_comb begin
    if (in_value[31]) coord = '0;
    else if (in_value[30:CB] != '0) coord = '1;
    else coord = in_value[CB-1:0];
  end

  // Absolute differences of the stored points.
  logic [CB-1:0] ax, ay;
  always_comb begin
    ax = (point_x[0] > point_x[1]) ? point_x[0] - point_x[1] : point_x[1] - point_x[0];
    ay = (point_y[0] > point_y[1]) ? point_y[0] - point_y[1] : point_y[1] - point_y[0];
  end

  // One root digit per cycle, pairs from the top of the shifted square.
  logic [DB+1:0] trial, rem_sh;
  always_comb begin
    rem_sh = {rem[DB-1:0], root_src[SB+16:SB+15]};
    trial = {root, 2'b01};
  end

  // One quotient bit per cycle.
  logic [DB:0] dsh;
  always_comb dsh = {drem[DB-1:0], num[NB-1]};

  // Signed center deltas and their Manhattan size, the clamped zoom ratio and its distance from 1.0.
  logic signed [18:0] ddx, ddy;
  logic [18:0] mx, my;
  logic [19:0] man;
  logic [33:0] dev;
  always_comb begin
    ddx = 19'(signed'({2'b00, cx})) - 19'(signed'({1'b0, prev_cx}));
    ddy = 19'(signed'({2'b00, cy})) - 19'(signed'({1'b0, prev_cy}));
    mx = ddx[18] ? 19'(-ddx) : ddx;
    my = ddy[18] ? 19'(-ddy) : ddy;
    man = {1'b0, mx} + {1'b0, my};
    ratio = (quo[QB-1:32] != '0) ? '1 : quo[31:0];
    dev = ({2'b00, ratio} > 34'(65536)) ? {2'b00, ratio} - 34'(65536)
                                        : 34'(65536) - {2'b00, ratio};
  end

  always_comb begin
    status.two = finger_down[0] && finger_down[1] && (&x_set) && (&y_set);
    status.active = active;
    status.first = first;
    status.prev_nonzero = prev_dist != '0;
    status.zoom_over = zoom_over_r;
    status.pan_over = pan_over_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      zoom_threshold <= 16'd328;
      pan_threshold <= 18'd2;
    end else if (cfg_we) begin
      if (cfg_index == tfg_pkg::CFG_ZOOM) zoom_threshold <= cfg_data[15:0];
      else pan_threshold <= cfg_data;
    end
  end

  // Slot state and gesture state.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_set <= '0;
      y_set <= '0;
      finger_down <= '0;
      slot_idx <= 1'b0;
      slot_ok <= 1'b1;
      active <= 1'b0;
      first <= 1'b0;
      prev_dist <= '0;
      prev_cx <= '0;
      prev_cy <= '0;
      point_x[0] <= '0;
      point_x[1] <= '0;
      point_y[0] <= '0;
      point_y[1] <= '0;
    end else begin
      if (cmd.event_load) begin
        case (in_cmd)
          tfg_pkg::CMD_SLOT: begin
            slot_ok <= (in_value[31:1] == '0);
            slot_idx <= in_value[0];
          end
          tfg_pkg::CMD_TRACK: if (slot_ok) begin
            finger_down[slot_idx] <= !in_value[31];
            if (in_value[31]) begin
              x_set[slot_idx] <= 1'b0;
              y_set[slot_idx] <= 1'b0;
              point_x[slot_idx] <= '0;
              point_y[slot_idx] <= '0;
            end
          end
          tfg_pkg::CMD_POS_X: if (slot_ok) begin
            point_x[slot_idx] <= coord;
            x_set[slot_idx] <= 1'b1;
          end
          tfg_pkg::CMD_POS_Y: if (slot_ok) begin
            point_y[slot_idx] <= coord;
            y_set[slot_idx] <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.emit_touch_on) begin
        active <= 1'b1;
        first <= 1'b1;
        prev_dist <= root;
        prev_cx <= {1'b0, cx};
        prev_cy <= {1'b0, cy};
      end
      if (cmd.emit_touch_off) begin
        active <= 1'b0;
        prev_dist <= '0;
        prev_cx <= '0;
        prev_cy <= '0;
      end
      if (cmd.commit) begin
        first <= 1'b0;
        prev_dist <= root;
        prev_cx <= {1'b0, cx};
        prev_cy <= {1'b0, cy};
      end
    end
  end

  // Arithmetic units and result staging.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      sq <= SB'(ax) * SB'(ax) + SB'(ay) * SB'(ay);
      cx <= {1'b0, point_x[0]} + {1'b0, point_x[1]};
      cy <= {1'b0, point_y[0]} + {1'b0, point_y[1]};
      rem <= '0;
      root <= '0;
    end
    // The first root step loads the shifted square, the others shift it.
    if (cmd.prep) root_src <= '0;
    else if (cmd.root_step) begin
      if (root_src == '0 && rem == '0 && root == '0) root_src <= {17'd0, sq} << 16;
      else root_src <= root_src << 2;
    end
    if (cmd.root_step) begin
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        root <= {root[DB-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        root <= {root[DB-2:0], 1'b0};
      end
    end
    if (cmd.div_start) begin
      num <= {root, 16'd0};
      drem <= '0;
      quo <= '0;
    end
    if (cmd.div_step) begin
      num <= num << 1;
      if (dsh >= {1'b0, prev_dist}) begin
        drem <= dsh - {1'b0, prev_dist};
        quo <= {quo[QB-2:0], 1'b1};
      end else begin
        drem <= dsh;
        quo <= {quo[QB-2:0], 1'b0};
      end
    end
    zoom_over_r <= dev > 34'(zoom_threshold);
    pan_over_r <= man > 20'(pan_threshold);
    if (cmd.emit_touch_on || cmd.emit_touch_off) begin
      res_kind <= tfg_pkg::KIND_TOUCH;
      res_touching <= cmd.emit_touch_on;
      res_cx <= '0;
      res_cy <= '0;
      res_zoom <= '0;
      res_dx <= '0;
      res_dy <= '0;
    end else if (cmd.emit_pinch || cmd.emit_pan) begin
      res_kind <= cmd.emit_pinch ? tfg_pkg::KIND_PINCH : tfg_pkg::KIND_PAN;
      res_touching <= 1'b0;
      res_cx <= cx;
      res_cy <= cy;
      res_zoom <= cmd.emit_pinch ? ratio : '0;
      res_dx <= cmd.emit_pan ? ddx[17:0] : '0;
      res_dy <= cmd.emit_pan ? ddy[17:0] : '0;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/tfg_controller.sv
// Controller state machine that sequences events, sync frames and results.
`default_nettype none
module tfg_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [2:0]        in_cmd,
  output logic                   in_ready,
  input  wire tfg_pkg::status_t  status,
  output tfg_pkg::cmd_t          cmd,
  output logic                   out_valid,
  output logic                   out_last,
  input  wire logic              out_ready
);
  tfg_pkg::state_t state, state_next;
  logic [5:0] count, count_next;
  logic pan_pend, pan_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfg_pkg::ST_IDLE;
      count <= '0;
      pan_pend <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pan_pend <= pan_pend_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    pan_pend_next = pan_pend;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_last = 1'b0;
    case (state)
      tfg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.event_load = 1'b1;
          if (in_cmd == tfg_pkg::CMD_SYNC) state_next = tfg_pkg::ST_PREP;
        end
      end
      tfg_pkg::ST_PREP: begin
        if (status.two) begin
          cmd.prep = 1'b1;
          count_next = 6'(tfg_pkg::RootSteps + 1);
          state_next = tfg_pkg::ST_ROOT;
        end else if (status.active) begin
          cmd.emit_touch_off = 1'b1;
          pan_pend_next = 1'b0;
          state_next = tfg_pkg::ST_OUT;
        end else state_next = tfg_pkg::ST_IDLE;
      end
      tfg_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        count_next = count - 6'd1;
        if (count == 6'd1) state_next = tfg_pkg::ST_EVAL;
      end
      tfg_pkg::ST_EVAL: begin
        if (!status.active) begin
          cmd.emit_touch_on = 1'b1;
          pan_pend_next = 1'b0;
          state_next = tfg_pkg::ST_OUT;
        end else if (status.first) begin
          cmd.commit = 1'b1;
          state_next = tfg_pkg::ST_IDLE;
        end else if (status.prev_nonzero) begin
          cmd.div_start = 1'b1;
          count_next = 6'(tfg_pkg::QuoSteps);
          state_next = tfg_pkg::ST_DIV;
        end else state_next = tfg_pkg::ST_PINCH;
      end
      tfg_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        count_next = count - 6'd1;
        if (count == 6'd1) state_next = tfg_pkg::ST_PINCH;
      end
      tfg_pkg::ST_PINCH: state_next = tfg_pkg::ST_PAN;
      tfg_pkg::ST_PAN: begin
        pan_pend_next = status.pan_over;
        if (status.prev_nonzero && status.zoom_over) begin
          cmd.emit_pinch = 1'b1;
          state_next = tfg_pkg::ST_OUT;
        end else if (status.pan_over) begin
          cmd.emit_pan = 1'b1;
          pan_pend_next = 1'b0;
          state_next = tfg_pkg::ST_OUT;
        end else state_next = tfg_pkg::ST_FINISH;
      end
      tfg_pkg::ST_OUT: begin
        out_valid = 1'b1;
        out_last = !pan_pend;
        if (out_ready) begin
          if (pan_pend) begin
            cmd.emit_pan = 1'b1;
            pan_pend_next = 1'b0;
            state_next = tfg_pkg::ST_OUT2;
          end else if (status.active && !status.first) state_next = tfg_pkg::ST_FINISH;
          else state_next = tfg_pkg::ST_IDLE;
        end
      end
      tfg_pkg::ST_OUT2: begin
        out_valid = 1'b1;
        out_last = 1'b1;
        if (out_ready) state_next = tfg_pkg::ST_FINISH;
      end
      tfg_pkg::ST_FINISH: begin
        cmd.commit = 1'b1;
        state_next = tfg_pkg::ST_IDLE;
      end
      default: state_next = tfg_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/tfg_checker.sv
// Port-level checker bound to the gesture detector top level.
`default_nettype none
`include "two_finger_gesture_detector_unit_assert.svh"
module tfg_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic         m_axis_tlast,
  input wire logic [111:0] m_axis_tdata
);
  `TFG_ASSERT_IMPL(a_no_overlap, clk, rst, m_axis_tvalid, !s_axis_tready)
  `TFG_ASSERT_IMPL(a_kind_range, clk, rst, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
  `TFG_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `TFG_ASSERT_IMPL(a_touch_last, clk, rst, m_axis_tvalid && m_axis_tdata[1:0] == 2'd0,
                   m_axis_tlast)
endmodule
bind two_finger_gesture_detector_unit tfg_checker u_chk (.*);
`default_nettype wire

>>> tb/two_finger_gesture_detector_unit_tb.sv
// Self-checking testbench of the two-finger gesture detector with a built-in predictor.
`timescale 1ns / 1ps
module two_finger_gesture_detector_unit_tb;

  typedef struct {
    logic [1:0]  kind;
    logic        touching;
    logic [16:0] center_x;
    logic [16:0] center_y;
    logic [31:0] zoom_ratio;
    logic [17:0] pan_dx;
    logic [17:0] pan_dy;
    logic        last;
  } report_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_we;
  logic         cfg_index;
  logic [17:0]  cfg_data;

  // Stimulus waiting to be sent and reports waiting to arrive.
  logic [39:0] event_queue[$];
  report_t     gesture_reports[$];
  int          errors;
  bit          quiet;
  bit          hold;
  int          stall_cycles;

  // Predictor copy of the block's configuration and state.
  logic [15:0] zoom_thr;
  logic [17:0] pan_thr;
  logic [15:0] pt_x[2];
  logic [15:0] pt_y[2];
  bit          have_x[2];
  bit          have_y[2];
  bit          down[2];
  logic [1:0]  slot;
  bit          active;
  bit          first;
  longint unsigned prev_dist;
  longint unsigned prev_cx;
  longint unsigned prev_cy;

  // Stimulus generator's view of the finger positions.
  int gen_x[2];
  int gen_y[2];

  two_finger_gesture_detector_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Distance in Q8: floor(sqrt(s * 65536)), two bits at a time.
  function automatic longint unsigned root_q8(longint unsigned s);
    longint unsigned root, rem, pair, trial;
    int sh;
    root = 0;
    rem = 0;
    for (int i = 32; i >= 0; i--) begin
      sh = 2 * i - 16;
      pair = (sh >= 0) ? ((s >> sh) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [15:0] clamp_coord(logic [31:0] v);
    if (v[31]) return 16'd0;
    if (v > 32'd65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic report_t make_report(logic [1:0] kind, logic touching,
      longint unsigned cx, longint unsigned cy, longint unsigned zoom,
      longint unsigned dx, longint unsigned dy);
    report_t r;
    r.kind = kind;
    r.touching = touching;
    r.center_x = cx[16:0];
    r.center_y = cy[16:0];
    r.zoom_ratio = zoom[31:0];
    r.pan_dx = dx[17:0];
    r.pan_dy = dy[17:0];
    r.last = 1'b0;
    return r;
  endfunction

  // Frame evaluation on sync; appends the reports it causes.
  task automatic eval_frame();
    longint unsigned ax, ay, distance, cx, cy, q, dev, mx, my;
    longint dx, dy;
    int n;
    bit two;
    n = 0;
    two = down[0] && down[1] && have_x[0] && have_y[0] && have_x[1] && have_y[1];
    if (two) begin
      ax = (pt_x[0] > pt_x[1]) ? pt_x[0] - pt_x[1] : pt_x[1] - pt_x[0];
      ay = (pt_y[0] > pt_y[1]) ? pt_y[0] - pt_y[1] : pt_y[1] - pt_y[0];
      distance = root_q8(ax * ax + ay * ay);
      cx = pt_x[0] + pt_x[1];
      cy = pt_y[0] + pt_y[1];
      if (!active) begin
        active = 1;
        first = 1;
        prev_dist = distance;
        prev_cx = cx;
        prev_cy = cy;
        gesture_reports.push_back(make_report(tfg_pkg::KIND_TOUCH, 1'b1, 0, 0, 0, 0, 0));
        n = 1;
      end else begin
        if (!first && prev_dist > 0) begin
          q = (distance << 16) / prev_dist;
          if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
          dev = (q > 65536) ? q - 65536 : 65536 - q;
          if (dev > zoom_thr) begin
            gesture_reports.push_back(
                make_report(tfg_pkg::KIND_PINCH, 1'b0, cx, cy, q, 0, 0));
            n++;
          end
        end
        prev_dist = distance;
        if (!first) begin
          dx = longint'(cx) - longint'(prev_cx);
          dy = longint'(cy) - longint'(prev_cy);
          mx = (dx < 0) ? -dx : dx;
          my = (dy < 0) ? -dy : dy;
          if (mx + my > pan_thr) begin
            gesture_reports.push_back(
                make_report(tfg_pkg::KIND_PAN, 1'b0, cx, cy, 0, dx, dy));
            n++;
          end
        end
        prev_cx = cx;
        prev_cy = cy;
        first = 0;
      end
    end else if (active) begin
      active = 0;
      prev_dist = 0;
      prev_cx = 0;
      prev_cy = 0;
      gesture_reports.push_back(make_report(tfg_pkg::KIND_TOUCH, 1'b0, 0, 0, 0, 0, 0));
      n = 1;
    end
    if (n > 0) gesture_reports[$].last = 1'b1;
  endtask

  // Predictor: update the state for one accepted request.
  task automatic predict_event(logic [2:0] cmd, logic [31:0] v);
    bit ok;
    ok = slot < 2;
    case (cmd)
      tfg_pkg::CMD_SLOT: slot = (!v[31] && v < 2) ? v[1:0] : 2'd2;
      tfg_pkg::CMD_TRACK: if (ok) begin
        down[slot] = !v[31];
        if (v[31]) begin
          have_x[slot] = 0;
          have_y[slot] = 0;
          pt_x[slot] = 0;
          pt_y[slot] = 0;
        end
      end
      tfg_pkg::CMD_POS_X: if (ok) begin
        pt_x[slot] = clamp_coord(v);
        have_x[slot] = 1;
      end
      tfg_pkg::CMD_POS_Y: if (ok) begin
        pt_y[slot] = clamp_coord(v);
        have_y[slot] = 1;
      end
      tfg_pkg::CMD_SYNC: eval_frame();
      default: ;
    endcase
  endtask

  task automatic push_event(logic [2:0] cmd, logic [31:0] v);
    event_queue.push_back({5'd0, v, cmd});
  endtask

  // Nudge a coordinate a little, keeping it in range.
  function automatic int nudge(int c);
    int r;
    r = c + $urandom_range(0, 8) - 4;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return r;
  endfunction

  // One well-formed frame for both fingers, then sync.
  task automatic push_frame();
    for (int s = 0; s < 2; s++) begin
      push_event(tfg_pkg::CMD_SLOT, s);
      if ($urandom_range(0, 9) == 0)
        push_event(tfg_pkg::CMD_TRACK, $urandom_range(0, 32767));
      if ($urandom_range(0, 19) == 0) begin
        gen_x[s] = $urandom_range(0, 65535);
        gen_y[s] = $urandom_range(0, 65535);
      end else begin
        gen_x[s] = nudge(gen_x[s]);
        gen_y[s] = nudge(gen_y[s]);
      end
      push_event(tfg_pkg::CMD_POS_X, gen_x[s]);
      push_event(tfg_pkg::CMD_POS_Y, gen_y[s]);
    end
    push_event(tfg_pkg::CMD_SYNC, $urandom);
  endtask

  task automatic push_touch_down();
    for (int s = 0; s < 2; s++) begin
      push_event(tfg_pkg::CMD_SLOT, s);
      push_event(tfg_pkg::CMD_TRACK, $urandom_range(0, 1000));
    end
  endtask

  task automatic push_random(int count);
    int r;
    while (event_queue.size() < count) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        push_frame();
      end else if (r < 80) begin
        push_touch_down();
      end else if (r < 86) begin
        // Lift one finger and sync.
        push_event(tfg_pkg::CMD_SLOT, $urandom_range(0, 1));
        push_event(tfg_pkg::CMD_TRACK, 32'h8000_0000 | $urandom);
        push_event(tfg_pkg::CMD_SYNC, 0);
      end else begin
        // Noise: any command, any value, including bad slots.
        push_event(3'($urandom_range(0, 7)), $urandom);
      end
    end
  endtask

  task automatic wait_drained();
    wait (event_queue.size() == 0 && !s_axis_tvalid && gesture_reports.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [17:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tfg_pkg::CFG_ZOOM) zoom_thr = data[15:0];
    else pan_thr = data;
  endtask

  // Driver: presents queued requests, with random gaps unless quiet is set.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_event(s_axis_tdata[2:0], s_axis_tdata[34:3]);
        void'(event_queue.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (!hold && event_queue.size() > 0 &&
                   (quiet || $urandom_range(0, 99) >= 9)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= event_queue[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure unless quiet is set, and field checks against the oldest report.
  always @(posedge clk) begin
    report_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 9);
      if (m_axis_tvalid && m_axis_tready) begin
        if (gesture_reports.size() == 0) begin
          $error("unexpected result tdata=%h", m_axis_tdata);
          errors++;
        end else begin
          e = gesture_reports.pop_front();
          if (m_axis_tdata[1:0] !== e.kind) begin
            $error("kind expected %0d actual %0d", e.kind, m_axis_tdata[1:0]);
            errors++;
          end
          if (m_axis_tdata[2] !== e.touching) begin
            $error("touching expected %0d actual %0d", e.touching, m_axis_tdata[2]);
            errors++;
          end
          if (m_axis_tdata[19:3] !== e.center_x) begin
            $error("center_x expected %0d actual %0d", e.center_x, m_axis_tdata[19:3]);
            errors++;
          end
          if (m_axis_tdata[36:20] !== e.center_y) begin
            $error("center_y expected %0d actual %0d", e.center_y, m_axis_tdata[36:20]);
            errors++;
          end
          if (m_axis_tdata[68:37] !== e.zoom_ratio) begin
            $error("zoom_ratio expected %h actual %h", e.zoom_ratio, m_axis_tdata[68:37]);
            errors++;
          end
          if (m_axis_tdata[86:69] !== e.pan_dx) begin
            $error("pan_dx expected %h actual %h", e.pan_dx, m_axis_tdata[86:69]);
            errors++;
          end
          if (m_axis_tdata[104:87] !== e.pan_dy) begin
            $error("pan_dy expected %h actual %h", e.pan_dy, m_axis_tdata[104:87]);
            errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last expected %0d actual %0d", e.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 20000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    quiet = 0;
    hold = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = tfg_pkg::CFG_ZOOM;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    zoom_thr = 16'd328;
    pan_thr = 18'd2;
    for (int s = 0; s < 2; s++) begin
      pt_x[s] = 0;
      pt_y[s] = 0;
      have_x[s] = 0;
      have_y[s] = 0;
      down[s] = 0;
      gen_x[s] = 30000;
      gen_y[s] = 30000;
    end
    slot = 0;
    active = 0;
    first = 0;
    prev_dist = 0;
    prev_cx = 0;
    prev_cy = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty sync, half-placed finger, bad slots, odd commands.
    push_event(tfg_pkg::CMD_SYNC, 32'hFFFF_FFFF);
    push_touch_down();
    push_event(tfg_pkg::CMD_POS_X, 100);
    push_event(tfg_pkg::CMD_SYNC, 0);
    push_event(tfg_pkg::CMD_SLOT, 32'hFFFF_FFFF);
    push_event(tfg_pkg::CMD_POS_Y, 5);
    push_event(tfg_pkg::CMD_SLOT, 2);
    push_event(tfg_pkg::CMD_TRACK, 32'h8000_0000);
    push_event(3'd5, 32'h7FFF_FFFF);
    push_event(3'd7, 32'h8000_0000);
    // Both fingers at one point: zero distance, then extreme coordinates.
    push_event(tfg_pkg::CMD_SLOT, 0);
    push_event(tfg_pkg::CMD_POS_X, 32'hFFFF_FFFF);
    push_event(tfg_pkg::CMD_POS_Y, 0);
    push_event(tfg_pkg::CMD_SLOT, 1);
    push_event(tfg_pkg::CMD_POS_X, 0);
    push_event(tfg_pkg::CMD_POS_Y, 0);
    push_event(tfg_pkg::CMD_SYNC, 0);
    push_event(tfg_pkg::CMD_SYNC, 0);
    push_event(tfg_pkg::CMD_POS_X, 32'h7FFF_FFFF);
    push_event(tfg_pkg::CMD_POS_Y, 70000);
    push_event(tfg_pkg::CMD_SYNC, 0);
    push_event(tfg_pkg::CMD_SLOT, 0);
    push_event(tfg_pkg::CMD_POS_X, 40000);
    push_event(tfg_pkg::CMD_SYNC, 0);
    push_event(tfg_pkg::CMD_TRACK, 32'hFFFF_FFFE);
    push_event(tfg_pkg::CMD_SYNC, 0);
    wait_drained();

    // Default thresholds, with a long stretch without gaps.
    quiet = 1;
    push_random(130);
    wait_drained();
    quiet = 0;

    // Lowest thresholds.
    write_reg(tfg_pkg::CFG_ZOOM, 18'd0);
    write_reg(tfg_pkg::CFG_PAN, 18'd0);
    push_random(100);
    wait_drained();

    // Highest zoom threshold and a pan threshold near its top.
    write_reg(tfg_pkg::CFG_ZOOM, 18'd65535);
    write_reg(tfg_pkg::CFG_PAN, 18'd262140);
    push_random(60);
    wait_drained();

    // Middle thresholds, pausing once mid-run until all reports are in.
    write_reg(tfg_pkg::CFG_ZOOM, 18'd2000);
    write_reg(tfg_pkg::CFG_PAN, 18'd6);
    push_random(50);
    wait (event_queue.size() == 0 && !s_axis_tvalid);
    hold = 1;
    push_random(60);
    wait (gesture_reports.size() == 0);
    repeat (100) @(posedge clk);
    hold = 0;
    wait_drained();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
